>>> sv/divide_64_signed_unsigned_unit_assert.svh
// assertion macros for the divider
`ifndef DIVIDE_64_SIGNED_UNSIGNED_UNIT_ASSERT_SVH
`define DIVIDE_64_SIGNED_UNSIGNED_UNIT_ASSERT_SVH

// same-cycle implication
`define D64_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define D64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/div64_pkg.sv
package div64_pkg;

	localparam int DATA_W = 64;
	localparam int STEPS  = DATA_W;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic  op;
		word_t dividend;
		word_t divisor;
	} in_item_t;

	typedef struct packed {
		word_t quotient;
		word_t remainder;
	} out_item_t;

	typedef struct packed {
		logic a_neg;
		logic q_neg;
		logic dz;
	} sign_t;

	// rem: partial remainder, num: dividend bits left in the high end, quotient bits in the low end
	typedef struct packed {
		word_t rem;
		word_t num;
		word_t den;
		sign_t sgn;
	} work_t;

endpackage

>>> sv/divide_64_signed_unsigned_unit.sv
// Pipelined 64-bit divider, unsigned (op 0) or signed two's complement (op 1), giving
// quotient truncated toward zero and remainder with the dividend's sign; divide by zero
// gives zero for both, and the most negative value over minus one wraps. One item is
// accepted per cycle while req_stall is low; each passes through one operand-magnitude
// stage, 64 restoring stages that each resolve one quotient bit with a 65-bit subtract,
// one sign-fix stage and the output register. A two-entry output buffer lets one more
// item in while a result waits; req_stall rises only when that buffer is full.
module divide_64_signed_unsigned_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  div64_pkg::in_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output div64_pkg::out_item_t rsp
);

	logic                         en;
	logic [div64_pkg::STEPS:0]    v;
	div64_pkg::work_t             w [div64_pkg::STEPS+1];
	logic                         fix_v;
	div64_pkg::out_item_t         fix_d;

	assign req_stall = !en;

	div64_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.in_item   (req),
		.out_valid (v[0]),
		.out_work  (w[0])
	);

	for (genvar k = 0; k < div64_pkg::STEPS; k++) begin : g_step
		div64_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v[k]),
			.in_work   (w[k]),
			.out_valid (v[k+1]),
			.out_work  (w[k+1])
		);
	end

	div64_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v[div64_pkg::STEPS]),
		.in_work   (w[div64_pkg::STEPS]),
		.out_valid (fix_v),
		.out_item  (fix_d)
	);

	div64_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fix_v),
		.in_item  (fix_d),
		.en       (en),
		.valid    (rsp_valid),
		.stall    (rsp_stall),
		.item     (rsp)
	);

endmodule

>>> sv/div64_prep.sv
module div64_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  div64_pkg::in_item_t  in_item,
	output logic                 out_valid,
	output div64_pkg::work_t     out_work
);

	logic             a_neg;
	logic             b_neg;
	div64_pkg::work_t nxt;
	logic             prep_v_s1;
	div64_pkg::work_t prep_s1;

	always_comb begin
		a_neg         = in_item.op & in_item.dividend[div64_pkg::DATA_W-1];
		b_neg         = in_item.op & in_item.divisor[div64_pkg::DATA_W-1];
		nxt.rem       = '0;
		nxt.num       = a_neg ? (~in_item.dividend) + div64_pkg::word_t'(1) : in_item.dividend;
		nxt.den       = b_neg ? (~in_item.divisor) + div64_pkg::word_t'(1) : in_item.divisor;
		nxt.sgn.a_neg = a_neg;
		nxt.sgn.q_neg = a_neg ^ b_neg;
		nxt.sgn.dz    = (in_item.divisor == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s1 <= 1'b0;
		end else if (en) begin
			prep_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= nxt;
		end
	end

	assign out_valid = prep_v_s1;
	assign out_work  = prep_s1;

endmodule

>>> sv/div64_step.sv
module div64_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  div64_pkg::work_t in_work,
	output logic             out_valid,
	output div64_pkg::work_t out_work
);

	logic [div64_pkg::DATA_W:0] trial;
	logic [div64_pkg::DATA_W:0] diff;
	logic                       fits;
	div64_pkg::work_t           nxt;
	logic                       step_v_s1;
	div64_pkg::work_t           step_s1;

	always_comb begin
		trial   = {in_work.rem, in_work.num[div64_pkg::DATA_W-1]};
		diff    = trial - {1'b0, in_work.den};
		fits    = !diff[div64_pkg::DATA_W];
		nxt     = in_work;
		nxt.rem = fits ? diff[div64_pkg::DATA_W-1:0] : trial[div64_pkg::DATA_W-1:0];
		nxt.num = {in_work.num[div64_pkg::DATA_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_v_s1 <= 1'b0;
		end else if (en) begin
			step_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign out_valid = step_v_s1;
	assign out_work  = step_s1;

endmodule

>>> sv/div64_fix.sv
module div64_fix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  div64_pkg::work_t     in_work,
	output logic                 out_valid,
	output div64_pkg::out_item_t out_item
);

	div64_pkg::out_item_t nxt;
	logic                 fix_v_s1;
	div64_pkg::out_item_t fix_s1;

	always_comb begin
		if (in_work.sgn.dz) begin
			nxt.quotient  = '0;
			nxt.remainder = '0;
		end else begin
			nxt.quotient  = in_work.sgn.q_neg ?
				(~in_work.num) + div64_pkg::word_t'(1) : in_work.num;
			nxt.remainder = in_work.sgn.a_neg ?
				(~in_work.rem) + div64_pkg::word_t'(1) : in_work.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_v_s1 <= 1'b0;
		end else if (en) begin
			fix_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fix_s1 <= nxt;
		end
	end

	assign out_valid = fix_v_s1;
	assign out_item  = fix_s1;

endmodule

>>> sv/div64_obuf.sv
`include "divide_64_signed_unsigned_unit_assert.svh"

module div64_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  div64_pkg::out_item_t in_item,
	output logic                 en,
	output logic                 valid,
	input  logic                 stall,
	output div64_pkg::out_item_t item
);

	logic                 out_v_q;
	logic                 skid_v_q;
	div64_pkg::out_item_t out_d_q;
	div64_pkg::out_item_t skid_d_q;

	// pipeline moves whenever the skid slot is free
	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (out_v_q && stall) begin
				skid_v_q <= in_valid;
			end else begin
				out_v_q <= in_valid;
			end
		end else if (!stall) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (out_v_q && stall) begin
				skid_d_q <= in_item;
			end else begin
				out_d_q <= in_item;
			end
		end else if (!stall) begin
			out_d_q <= skid_d_q;
		end
	end

	assign valid = out_v_q;
	assign item  = out_d_q;

	`D64_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q, "skid holds an item but output is empty")
	`D64_ASSERT_NEXT(a_skid_drains, skid_v_q && !stall, !skid_v_q && out_v_q, "skid not drained")
	`D64_ASSERT_NEXT(a_skid_fills, !skid_v_q && out_v_q && stall && in_valid, skid_v_q, "item lost")

endmodule
